@@ hw/rtl/e8cu_pkg.sv @@
// Package for the E8 call address untranslation block.
// Holds shared constants and the queue entry type; no dependencies.
`default_nettype none
package e8cu_pkg;

  localparam int FS_W = 31;
  localparam int POS_W = 32;
  localparam int LEN_W = 16;
  localparam int IDX_W = 15;
  localparam int GROUP_BYTES = 5;

  localparam logic [LEN_W-1:0] FRAME_LIMIT = 16'd32768;
  localparam logic [LEN_W:0] TAIL_SKIP = 17'd10;
  localparam logic [LEN_W-1:0] MAX_FRAME = 16'd32768;
  localparam logic [LEN_W-1:0] MIN_XLATE_LEN = 16'd6;
  localparam logic [7:0] CALL_OPCODE = 8'hE8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic group;
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [POS_W-1:0] pos;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/e8cu_front.sv @@
// Front part: accepts bytes, tracks frames and position, collects call groups.
// Depends on e8cu_pkg; pushes one entry per passed byte or completed group.
`default_nettype none
module e8cu_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire logic                     q_full,
  input  wire logic [7:0]               data_byte,
  input  wire logic [15:0]              frame_bytes,
  input  wire logic                     translate_allowed,
  input  wire logic [e8cu_pkg::FS_W-1:0] file_size,
  output logic                          q_push,
  output e8cu_pkg::entry_t              q_data
);
  import e8cu_pkg::*;

  logic [POS_W-1:0] stream_position, stream_position_next;
  logic [LEN_W-1:0] frame_count, frame_count_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic             frame_active, frame_active_next;
  logic [2:0]       held_count, held_count_next;
  logic [LEN_W-1:0] cur_len;
  logic             tracked, translated;
  logic [3:0][7:0]  held;

  logic             accept;
  logic [LEN_W-1:0] len_new, len_eff;
  logic             tracked_new, translated_new, tracked_eff, translated_eff;
  logic [IDX_W-1:0] bi_eff;
  logic [2:0]       hc_eff;
  logic [LEN_W:0]   tail_sum;
  logic [LEN_W-1:0] bi_inc;
  logic             start_call, store_byte;

  assign accept = push && !q_full;

  always_comb begin
    if (frame_bytes == '0) begin
      len_new = 16'd1;
    end else if (frame_bytes > MAX_FRAME) begin
      len_new = MAX_FRAME;
    end else begin
      len_new = frame_bytes;
    end
    tracked_new    = (frame_count < FRAME_LIMIT) && (file_size != '0);
    translated_new = tracked_new && (len_new > MIN_XLATE_LEN) && translate_allowed;
    len_eff        = frame_active ? cur_len : len_new;
    tracked_eff    = frame_active ? tracked : tracked_new;
    translated_eff = frame_active ? translated : translated_new;
    bi_eff         = frame_active ? byte_index : '0;
    hc_eff         = frame_active ? held_count : 3'd0;
    frame_count_next = frame_count;
    if (!frame_active && (frame_count < FRAME_LIMIT)) begin
      frame_count_next = frame_count + 16'd1;
    end

    tail_sum   = {2'b00, bi_eff} + TAIL_SKIP;
    start_call = translated_eff && (data_byte == CALL_OPCODE) &&
                 (tail_sum < {1'b0, len_eff});

    q_push               = 1'b0;
    q_data.group         = 1'b0;
    q_data.bytes         = {held[3], held[2], held[1], held[0], data_byte};
    q_data.pos           = stream_position;
    store_byte           = 1'b0;
    held_count_next      = hc_eff;
    stream_position_next = stream_position;

    if (hc_eff != 3'd0) begin
      if (hc_eff == 3'd4) begin
        q_push               = accept;
        q_data.group         = 1'b1;
        q_data.bytes         = {data_byte, held[3], held[2], held[1], held[0]};
        held_count_next      = 3'd0;
        stream_position_next = stream_position + 32'd5;
      end else begin
        store_byte      = 1'b1;
        held_count_next = hc_eff + 3'd1;
      end
    end else if (start_call) begin
      store_byte      = 1'b1;
      held_count_next = 3'd1;
    end else begin
      q_push = accept;
      if (tracked_eff) begin
        stream_position_next = stream_position + 32'd1;
      end
    end

    bi_inc = {1'b0, bi_eff} + 16'd1;
    if (bi_inc >= len_eff) begin
      frame_active_next = 1'b0;
      byte_index_next   = '0;
    end else begin
      frame_active_next = 1'b1;
      byte_index_next   = bi_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_position <= '0;
      frame_count     <= '0;
      byte_index      <= '0;
      frame_active    <= 1'b0;
      held_count      <= '0;
      cur_len         <= '0;
      tracked         <= 1'b0;
      translated      <= 1'b0;
    end else if (accept) begin
      stream_position <= stream_position_next;
      frame_count     <= frame_count_next;
      byte_index      <= byte_index_next;
      frame_active    <= frame_active_next;
      held_count      <= held_count_next;
      cur_len         <= len_eff;
      tracked         <= tracked_eff;
      translated      <= translated_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_byte) begin
      held[hc_eff[1:0]] <= data_byte;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/e8cu_fifo.sv @@
// Short queue of entries between the front and back parts.
// Depends on e8cu_pkg for the entry type and depth.
`default_nettype none
module e8cu_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire e8cu_pkg::entry_t wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output e8cu_pkg::entry_t  rd_data,
  output logic              rd_valid
);
  import e8cu_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr, do_rd;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/e8cu_back.sv @@
// Back part: rewrites call offsets and unrolls entries into single results.
// Depends on e8cu_pkg; reads entries from the queue, drives the result side.
`default_nettype none
module e8cu_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [e8cu_pkg::FS_W-1:0] file_size,
  input  wire e8cu_pkg::entry_t         q_data,
  input  wire logic                     q_valid,
  output logic                          q_pop,
  input  wire logic                     pop,
  output logic                          empty,
  output logic [7:0]                    out_byte,
  output logic                          end_of_burst
);
  import e8cu_pkg::*;

  logic                         out_valid;
  logic                         group;
  logic [GROUP_BYTES-1:0][7:0]  bytes;
  logic [2:0]                   idx;

  logic [31:0]                  raw, res;
  logic [33:0]                  low_sum;
  logic                         in_range, last;
  logic [GROUP_BYTES-1:0][7:0]  fixed;

  always_comb begin
    raw      = {q_data.bytes[4], q_data.bytes[3], q_data.bytes[2], q_data.bytes[1]};
    low_sum  = {{2{raw[31]}}, raw} + {2'b00, q_data.pos};
    in_range = !low_sum[33] &&
               ($signed({raw[31], raw}) < $signed({2'b00, file_size}));
    res      = raw[31] ? (raw + {1'b0, file_size}) : (raw - q_data.pos);
    fixed    = q_data.bytes;
    if (q_data.group && in_range) begin
      fixed = {res[31:24], res[23:16], res[15:8], res[7:0], q_data.bytes[0]};
    end
  end

  assign last         = !group || (idx == 3'd4);
  assign empty        = !out_valid;
  assign end_of_burst = last;
  assign out_byte     = bytes[idx];
  assign q_pop        = q_valid && (!out_valid || (pop && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (out_valid && pop) begin
      if (last) begin
        out_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      group <= q_data.group;
      bytes <= fixed;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/e8_call_address_untranslate.sv @@
// Top level of the E8 call address untranslation block.
// Depends on e8cu_pkg, e8cu_front, e8cu_fifo and e8cu_back.
//
// Usage:
//   Input side is a queue write port: an item (data_byte, frame_bytes,
//   translate_allowed) is taken on a rising edge with push high and full low.
//   Result side is a queue read port: out_byte/end_of_burst show the oldest
//   result while empty is low; it is taken on an edge with pop high.
//   cfg_we/cfg_wdata write file_size (zero turns translation off); write it
//   only while the block is idle.
//   A passed byte goes through the queue and then the output register before it
//   is shown, and can be taken at the next edge. A call group takes the same
//   path after its fifth byte, as five results with end_of_burst on the last.
//   Throughput: one item per cycle while full is low; the back part issues one
//   result per cycle with pop high; a four-entry queue before it absorbs groups.
//   Stalls: with pop low the output holds, the queue fills and full rises.
//   Reset: clears position, frame count, frame state, file_size and queue;
//   empty is high and full is low afterwards.
`default_nettype none
module e8_call_address_untranslate (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic [15:0] frame_bytes,
  input  wire logic        translate_allowed,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             end_of_burst,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata
);
  import e8cu_pkg::*;

  logic [FS_W-1:0] file_size;
  logic            q_push, q_full, q_pop, q_valid;
  entry_t          q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (cfg_we) begin
      file_size <= cfg_wdata;
    end
  end

  assign full = q_full;

  e8cu_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .q_full            (q_full),
    .data_byte         (data_byte),
    .frame_bytes       (frame_bytes),
    .translate_allowed (translate_allowed),
    .file_size         (file_size),
    .q_push            (q_push),
    .q_data            (q_wdata)
  );

  e8cu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_rdata),
    .rd_valid (q_valid)
  );

  e8cu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .file_size    (file_size),
    .q_data       (q_rdata),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .end_of_burst (end_of_burst)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("queue written while full");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty) else $error("result side not empty after reset");

  a_refill_output: assert property (@(posedge clk) disable iff (rst)
    (empty && q_valid) |=> !empty) else $error("queued entry not moved to output");

  a_push_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (push && !full)) else $error("queue written without an accepted item");

endmodule
`default_nettype wire

@@ bench/e8cu_checker.sv @@
// Checker for the E8 call address untranslation block: watches the item and
// result queues, predicts every result and compares it field by field.
// Depends on e8cu_pkg for the block's constants.
`timescale 1ns / 1ps
module e8cu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic [15:0] frame_bytes,
  input  logic        translate_allowed,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        end_of_burst,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata,
  output int          fails,
  output int          due
);
  import e8cu_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } out_item_t;

  out_item_t   bytes_due[$];
  out_item_t   oldest;
  logic [30:0] file_sz;
  logic [31:0] stream_pos;
  int          frame_cnt;
  int          byte_idx;
  int          frame_len;
  int          held_cnt;
  logic        in_frame;
  logic        tracked;
  logic        translated;
  logic [7:0]  held [GROUP_BYTES];
  int          err_total;

  task automatic untranslate_item(input logic [7:0] b, input logic [15:0] fb,
                                  input logic ta);
    int          len;
    logic [31:0] raw;
    logic [31:0] res;
    longint      off;
    longint      p;
    longint      fs;
    if (!in_frame) begin
      len = (fb == 16'd0) ? 1 : int'(fb);
      if (len > int'(MAX_FRAME)) len = int'(MAX_FRAME);
      frame_len = len;
      tracked = (frame_cnt < int'(FRAME_LIMIT)) && (file_sz != 31'd0);
      translated = tracked && (len > int'(MIN_XLATE_LEN)) && ta;
      if (frame_cnt < int'(FRAME_LIMIT)) frame_cnt++;
      in_frame = 1'b1;
      byte_idx = 0;
      held_cnt = 0;
    end
    if (held_cnt > 0) begin
      held[held_cnt] = b;
      held_cnt++;
      if (held_cnt == GROUP_BYTES) begin
        raw = {held[4], held[3], held[2], held[1]};
        off = $signed(raw);
        p = stream_pos;
        fs = file_sz;
        if (off >= -p && off < fs) begin
          res = (off >= 0) ? raw - stream_pos : raw + {1'b0, file_sz};
          held[1] = res[7:0];
          held[2] = res[15:8];
          held[3] = res[23:16];
          held[4] = res[31:24];
        end
        for (int k = 0; k < GROUP_BYTES; k++)
          bytes_due.push_back('{held[k], k == GROUP_BYTES - 1});
        held_cnt = 0;
        stream_pos += GROUP_BYTES;
      end
    end else if (translated && b == CALL_OPCODE &&
                 byte_idx + int'(TAIL_SKIP) < frame_len) begin
      held[0] = b;
      held_cnt = 1;
    end else begin
      bytes_due.push_back('{b, 1'b1});
      if (tracked) stream_pos += 32'd1;
    end
    byte_idx++;
    if (byte_idx >= frame_len) begin
      in_frame = 1'b0;
      byte_idx = 0;
    end
  endtask

  initial begin
    err_total = 0;
    fails = 0;
    due = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      bytes_due.delete();
      file_sz = '0;
      stream_pos = '0;
      frame_cnt = 0;
      byte_idx = 0;
      frame_len = 0;
      held_cnt = 0;
      in_frame = 1'b0;
      tracked = 1'b0;
      translated = 1'b0;
    end else begin
      if (cfg_we) file_sz = cfg_wdata;
      if (push && !full) untranslate_item(data_byte, frame_bytes, translate_allowed);
      if (pop && !empty) begin
        if (bytes_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual out_byte %02h eob %0b",
                   $time, out_byte, end_of_burst);
          err_total++;
        end else begin
          oldest = bytes_due.pop_front();
          if (out_byte !== oldest.b) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, oldest.b, out_byte);
            err_total++;
          end
          if (end_of_burst !== oldest.last) begin
            $display("%0t: end_of_burst expected %0b actual %0b", $time, oldest.last,
                     end_of_burst);
            err_total++;
          end
        end
      end
    end
    fails <= err_total;
    due <= bytes_due.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the E8 call address untranslation testbench: drives frames of bytes
// and file_size settings, stalls the result side, and gives the verdict.
// Depends on e8cu_pkg, the block and e8cu_checker.
`timescale 1ns / 1ps
module tb_top;
  import e8cu_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic [15:0] frame_bytes = 16'h0000;
  logic        translate_allowed = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        end_of_burst;
  logic        cfg_we = 1'b0;
  logic [30:0] cfg_wdata = 31'd0;
  int          fails;
  int          due;

  logic [7:0]  frame_q[$];
  logic [30:0] fs_now = 31'd0;
  logic [31:0] tracked_bytes = 32'd0;
  int          frames_started = 0;
  int          items_sent = 0;
  bit          calm = 1'b0;

  e8_call_address_untranslate dut (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .data_byte         (data_byte),
    .frame_bytes       (frame_bytes),
    .translate_allowed (translate_allowed),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .end_of_burst      (end_of_burst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  e8cu_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .data_byte         (data_byte),
    .frame_bytes       (frame_bytes),
    .translate_allowed (translate_allowed),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .end_of_burst      (end_of_burst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .fails             (fails),
    .due               (due)
  );

  always #5 clk = ~clk;

  task automatic send_item(input logic [7:0] b, input logic [15:0] fb, input logic ta);
    push <= 1'b1;
    data_byte <= b;
    frame_bytes <= fb;
    translate_allowed <= ta;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_file_size(input logic [30:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fs_now = v;
    @(posedge clk);
  endtask

  // fill with random bytes; plant call groups whose offsets sit near the range edges or are random
  task automatic build_frame(input int len);
    int          i;
    logic [31:0] off;
    logic [31:0] p;
    frame_q.delete();
    i = 0;
    while (i < len) begin
      if (i + int'(TAIL_SKIP) < len && $urandom_range(0, 3) == 0) begin
        p = tracked_bytes + i;
        case ($urandom_range(0, 9))
          0: off = -p;
          1: off = -p - 32'd1;
          2: off = {1'b0, fs_now} - 32'd1;
          3: off = {1'b0, fs_now};
          4: off = 32'd0;
          5: off = 32'h7FFF_FFFF;
          6: off = 32'h8000_0000;
          7: off = $urandom;
          default: off = $urandom_range(0, 1200) - 32'd600;
        endcase
        frame_q.push_back(CALL_OPCODE);
        frame_q.push_back(off[7:0]);
        frame_q.push_back(off[15:8]);
        frame_q.push_back(off[23:16]);
        frame_q.push_back(off[31:24]);
        i += GROUP_BYTES;
      end else begin
        frame_q.push_back(($urandom_range(0, 7) == 0) ? CALL_OPCODE
                                                       : 8'($urandom_range(0, 255)));
        i++;
      end
    end
  endtask

  task automatic play_frame(input logic [15:0] len_field, input logic ta, input bit mid);
    bit tr;
    tr = (fs_now != 31'd0) && (frames_started < int'(FRAME_LIMIT));
    for (int k = 0; k < frame_q.size(); k++) begin
      if (k == 0 || !mid)
        send_item(frame_q[k], len_field, ta);
      else
        send_item(frame_q[k], 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end
    frames_started++;
    if (tr) tracked_bytes += frame_q.size();
  endtask

  initial begin
    forever begin
      if (calm) begin
        pop <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [31:0] t;
    logic [15:0] lf;
    logic [30:0] fs_v;
    int          n;
    int          target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero length frame, short frames, one rewritten group
    frame_q = {8'h00};
    play_frame(16'd0, 1'b1, 1'b0);
    set_file_size(31'h7FFF_FFFF);
    frame_q = {CALL_OPCODE, 8'hFF, 8'h00, CALL_OPCODE, 8'h7F, 8'h80, 8'h01};
    play_frame(16'd7, 1'b1, 1'b0);
    t = -tracked_bytes;
    frame_q = {CALL_OPCODE, t[7:0], t[15:8], t[23:16], t[31:24], CALL_OPCODE,
               8'hFF, 8'h00, CALL_OPCODE, 8'h55, 8'hAA};
    play_frame(16'd11, 1'b1, 1'b0);
    frame_q = {CALL_OPCODE, CALL_OPCODE, 8'h01, 8'h02, 8'h04, 8'h08};
    play_frame(16'd6, 1'b1, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: fs_v = 31'd200;
        1: fs_v = 31'd0;
        2: fs_v = 31'd1;
        3: fs_v = 31'h7FFF_FFFF;
        4: fs_v = 31'd5000;
        default: fs_v = 31'($urandom);
      endcase
      set_file_size(fs_v);
      target = items_sent + 34;
      while (items_sent < target) begin
        case ($urandom_range(0, 9))
          0: lf = 16'd0;
          1: lf = 16'd6;
          2: lf = 16'd7;
          3: lf = 16'($urandom_range(10, 11));
          4: lf = 16'd12;
          default: lf = 16'($urandom_range(1, 40));
        endcase
        n = (lf == 16'd0) ? 1 : int'(lf);
        build_frame(n);
        play_frame(lf, 1'($urandom_range(0, 3) != 0), $urandom_range(0, 3) == 0);
      end
    end

    // last frame with no idling on either side
    set_file_size(31'd20000);
    calm = 1'b1;
    build_frame(30);
    play_frame(16'd30, 1'b1, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/e8cu_pkg.sv
hw/rtl/e8cu_front.sv
hw/rtl/e8cu_fifo.sv
hw/rtl/e8cu_back.sv
hw/rtl/e8_call_address_untranslate.sv
bench/e8cu_checker.sv
bench/tb_top.sv
